/* src/qte_pkg.sv */
`default_nettype none
package qte_pkg;

   localparam int QuatW        = 16;
   localparam int QuatFracBits = 14;
   localparam int ProdW        = 2 * QuatW;
   // Sums carry 2*QuatFracBits fraction bits plus sign and integer headroom.
   localparam int SumW         = 2 * QuatFracBits + 7;
   // The pitch sine magnitude is rescaled to 30 fraction bits.
   localparam int MagW         = 30;
   localparam int PitchUpShift = MagW - 2 * QuatFracBits;
   localparam int RadW         = 2 * MagW + 1;
   localparam int RootW        = MagW + 1;
   localparam int IsqrtStages  = (RadW + 1) / 2;

   localparam int NormW   = 30;
   localparam int NormTop = NormW - 1;
   localparam int PosW    = $clog2(SumW);
   localparam int XyW     = NormW + 3;
   localparam int AngW    = 32;
   localparam int AngOutW = 16;
   localparam int FineShift = 16;
   localparam int TableLen  = 24;

   localparam int CordicStepsDefault = 16;
   localparam int AtanFixedStages    = 5;
   localparam int FrontStages        = 3;
   localparam int QueueDepth         = 8;

   localparam int RollW  = 15;
   localparam int PitchW = 14;
   localparam int YawW   = 15;

   localparam logic signed [AngW-1:0]    Deg180Fine = 32'sd754974720;
   localparam logic signed [AngW-1:0]    RoundHalf  = 32'sd32768;
   localparam logic signed [AngOutW-1:0] Lim180     = 16'sd11520;
   localparam logic signed [AngOutW-1:0] Lim90      = 16'sd5760;

   typedef struct packed {
      logic signed [SumW-1:0] sin_roll;
      logic signed [SumW-1:0] cos_roll;
      logic signed [SumW-1:0] sin_yaw;
      logic signed [SumW-1:0] cos_yaw;
      logic [MagW-1:0]        pitch_mag;
      logic                   pitch_neg;
      logic                   pitch_clamped;
   } qte_item_type;

   // atan(2^-idx) in units of 2^-16 of 1/64 degree.
   function automatic logic signed [AngW-1:0] atan_fine(input int unsigned idx);
      logic signed [AngW-1:0] a;
      unique case (idx)
         0:  a = 32'sd188743680;
         1:  a = 32'sd111421900;
         2:  a = 32'sd58872272;
         3:  a = 32'sd29884485;
         4:  a = 32'sd15000234;
         5:  a = 32'sd7507429;
         6:  a = 32'sd3754631;
         7:  a = 32'sd1877430;
         8:  a = 32'sd938729;
         9:  a = 32'sd469366;
         10: a = 32'sd234683;
         11: a = 32'sd117342;
         12: a = 32'sd58671;
         13: a = 32'sd29335;
         14: a = 32'sd14668;
         15: a = 32'sd7334;
         16: a = 32'sd3667;
         17: a = 32'sd1833;
         18: a = 32'sd917;
         19: a = 32'sd458;
         20: a = 32'sd229;
         21: a = 32'sd115;
         22: a = 32'sd57;
         23: a = 32'sd29;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* src/qte_front.sv */
`default_nettype none
module qte_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [qte_pkg::QuatW-1:0] quat_w,
   input  wire logic signed [qte_pkg::QuatW-1:0] quat_x,
   input  wire logic signed [qte_pkg::QuatW-1:0] quat_y,
   input  wire logic signed [qte_pkg::QuatW-1:0] quat_z,
   output qte_pkg::qte_item_type              item,
   output logic                               item_valid
);
   import qte_pkg::*;

   localparam logic signed [SumW-1:0] One = SumW'(1) << (2 * QuatFracBits);

   logic signed [ProdW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [SumW-1:0]  sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   logic signed [SumW-1:0]  sr_in, cr_in, sp_in, sy_in, cy_in;
   logic [SumW-1:0]         sp_mag;
   qte_item_type            item_ff, item_in;

   always_ff @(posedge clock) begin
      wx_ff <= quat_w * quat_x;
      yz_ff <= quat_y * quat_z;
      xx_ff <= quat_x * quat_x;
      yy_ff <= quat_y * quat_y;
      wy_ff <= quat_w * quat_y;
      zx_ff <= quat_z * quat_x;
      wz_ff <= quat_w * quat_z;
      xy_ff <= quat_x * quat_y;
      zz_ff <= quat_z * quat_z;
   end

   always_comb begin
      sr_in = (SumW'(wx_ff) + SumW'(yz_ff)) <<< 1;
      cr_in = One - ((SumW'(xx_ff) + SumW'(yy_ff)) <<< 1);
      sp_in = (SumW'(wy_ff) - SumW'(zx_ff)) <<< 1;
      sy_in = (SumW'(wz_ff) + SumW'(xy_ff)) <<< 1;
      cy_in = One - ((SumW'(yy_ff) + SumW'(zz_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      cr_ff <= cr_in;
      sp_ff <= sp_in;
      sy_ff <= sy_in;
      cy_ff <= cy_in;
   end

   // Classify the pitch term: clamp when the sine reaches one in magnitude.
   always_comb begin
      sp_mag                = sp_ff[SumW-1] ? SumW'(-sp_ff) : SumW'(sp_ff);
      item_in.sin_roll      = sr_ff;
      item_in.cos_roll      = cr_ff;
      item_in.sin_yaw       = sy_ff;
      item_in.cos_yaw       = cy_ff;
      item_in.pitch_neg     = sp_ff[SumW-1];
      item_in.pitch_clamped = sp_mag >= SumW'(One);
      item_in.pitch_mag     = MagW'(sp_mag << PitchUpShift);
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign item       = item_ff;
   assign item_valid = v3_ff;

endmodule
`default_nettype wire

/* src/qte_queue.sv */
`default_nettype none
module qte_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  qte_pkg::qte_item_type push_item,
   output qte_pkg::qte_item_type pop_item,
   output logic               pop_valid,
   output logic               almost_full
);
   import qte_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   qte_item_type    entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   // The back part never stalls, so an entry leaves as soon as it is there.
   assign pop       = count_ff != '0;
   assign pop_valid = pop;
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Leave room for the items still inside the front pipeline.
   assign almost_full = count_ff >= CntW'(QueueDepth - FrontStages);

   always_comb begin
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

/* src/qte_isqrt.sv */
`default_nettype none
module qte_isqrt (
   input  wire logic                        clock,
   input  wire logic [qte_pkg::RadW-1:0]    radicand,
   output logic      [qte_pkg::RootW-1:0]   root
);
   import qte_pkg::*;

   localparam int WorkW = RadW + 1;

   logic [WorkW-1:0] v_ff [IsqrtStages];
   logic [WorkW-1:0] r_ff [IsqrtStages];
   logic [WorkW-1:0] v_stage [IsqrtStages+1];
   logic [WorkW-1:0] r_stage [IsqrtStages+1];

   assign v_stage[0] = WorkW'(radicand);
   assign r_stage[0] = '0;

   // One restoring digit per stage, highest power of four first.
   for (genvar k = 0; k < IsqrtStages; k++) begin : g_step
      localparam logic [WorkW-1:0] StepBit = WorkW'(1) << (2 * (IsqrtStages - 1 - k));
      logic [WorkW-1:0] trial, v_in, r_in;

      always_comb begin
         trial = r_stage[k] + StepBit;
         if (v_stage[k] >= trial) begin
            v_in = v_stage[k] - trial;
            r_in = (r_stage[k] >> 1) + StepBit;
         end else begin
            v_in = v_stage[k];
            r_in = r_stage[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[k] <= v_in;
         r_ff[k] <= r_in;
      end

      assign v_stage[k+1] = v_ff[k];
      assign r_stage[k+1] = r_ff[k];
   end

   assign root = RootW'(r_stage[IsqrtStages]);

endmodule
`default_nettype wire

/* src/qte_atan2.sv */
`default_nettype none
module qte_atan2 #(
   parameter int CORDIC_STEPS = qte_pkg::CordicStepsDefault
) (
   input  wire logic                               clock,
   input  wire logic signed [qte_pkg::SumW-1:0]    y_in,
   input  wire logic signed [qte_pkg::SumW-1:0]    x_in,
   output logic signed      [qte_pkg::AngOutW-1:0] angle
);
   import qte_pkg::*;

   // Operand magnitudes, then leading-one position, then normalizing shift.
   logic [SumW-1:0]  ax0_ff, ay0_ff, m0_ff;
   logic             nx0_ff, ny0_ff;
   logic [SumW-1:0]  ax1_ff, ay1_ff;
   logic             nx1_ff, ny1_ff, zero1_ff;
   logic [PosW-1:0]  pos1_ff, pos_in;
   logic [NormW-1:0] ax2_ff, ay2_ff, ax2_in, ay2_in;
   logic             nx2_ff, ny2_ff, zero2_ff;

   logic signed [XyW-1:0] xs_ff [CORDIC_STEPS+1];
   logic signed [XyW-1:0] ys_ff [CORDIC_STEPS+1];
   logic signed [AngW-1:0] z_ff [CORDIC_STEPS+1];
   logic                  zero_ff [CORDIC_STEPS+1];
   logic signed [XyW-1:0] ys0_in;
   logic signed [AngW-1:0] z0_in;
   logic signed [AngW-1:0] rnd;
   logic signed [AngOutW-1:0] angle_ff;

   always_ff @(posedge clock) begin
      ax0_ff <= x_in[SumW-1] ? SumW'(-x_in) : SumW'(x_in);
      ay0_ff <= y_in[SumW-1] ? SumW'(-y_in) : SumW'(y_in);
      m0_ff  <= (x_in[SumW-1] ? SumW'(-x_in) : SumW'(x_in)) >
                (y_in[SumW-1] ? SumW'(-y_in) : SumW'(y_in)) ?
                (x_in[SumW-1] ? SumW'(-x_in) : SumW'(x_in)) :
                (y_in[SumW-1] ? SumW'(-y_in) : SumW'(y_in));
      nx0_ff <= x_in[SumW-1];
      ny0_ff <= y_in[SumW-1];
   end

   always_comb begin
      pos_in = '0;
      for (int i = 0; i < SumW; i++) begin
         if (m0_ff[i]) begin
            pos_in = PosW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      ax1_ff   <= ax0_ff;
      ay1_ff   <= ay0_ff;
      nx1_ff   <= nx0_ff;
      ny1_ff   <= ny0_ff;
      zero1_ff <= m0_ff == '0;
      pos1_ff  <= pos_in;
   end

   // Bring the larger magnitude into [2^29, 2^30); right shifts truncate.
   always_comb begin
      if (pos1_ff > PosW'(NormTop)) begin
         ax2_in = NormW'(ax1_ff >> (pos1_ff - PosW'(NormTop)));
         ay2_in = NormW'(ay1_ff >> (pos1_ff - PosW'(NormTop)));
      end else begin
         ax2_in = NormW'(ax1_ff << (PosW'(NormTop) - pos1_ff));
         ay2_in = NormW'(ay1_ff << (PosW'(NormTop) - pos1_ff));
      end
   end

   always_ff @(posedge clock) begin
      ax2_ff   <= ax2_in;
      ay2_ff   <= ay2_in;
      nx2_ff   <= nx1_ff;
      ny2_ff   <= ny1_ff;
      zero2_ff <= zero1_ff;
   end

   // A negative x is turned by a half circle before the iterations.
   always_comb begin
      if (nx2_ff) begin
         z0_in  = ny2_ff ? -Deg180Fine : Deg180Fine;
         ys0_in = ny2_ff ? XyW'(ay2_ff) : -XyW'(ay2_ff);
      end else begin
         z0_in  = '0;
         ys0_in = ny2_ff ? -XyW'(ay2_ff) : XyW'(ay2_ff);
      end
   end

   always_ff @(posedge clock) begin
      xs_ff[0]   <= XyW'(ax2_ff);
      ys_ff[0]   <= ys0_in;
      z_ff[0]    <= z0_in;
      zero_ff[0] <= zero2_ff;
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      logic signed [XyW-1:0]  dx, dy, xs_in, ys_in;
      logic signed [AngW-1:0] z_in;

      always_comb begin
         dx = ys_ff[k] >>> k;
         dy = xs_ff[k] >>> k;
         if (!ys_ff[k][XyW-1]) begin
            xs_in = xs_ff[k] + dx;
            ys_in = ys_ff[k] - dy;
            z_in  = z_ff[k] + atan_fine(k);
         end else begin
            xs_in = xs_ff[k] - dx;
            ys_in = ys_ff[k] + dy;
            z_in  = z_ff[k] - atan_fine(k);
         end
      end

      always_ff @(posedge clock) begin
         xs_ff[k+1]   <= xs_in;
         ys_ff[k+1]   <= ys_in;
         z_ff[k+1]    <= z_in;
         zero_ff[k+1] <= zero_ff[k];
      end
   end

   // Round to nearest with ties upward; both operands zero give zero.
   assign rnd = (z_ff[CORDIC_STEPS] + RoundHalf) >>> FineShift;

   always_ff @(posedge clock) begin
      angle_ff <= zero_ff[CORDIC_STEPS] ? '0 : AngOutW'(rnd);
   end

   assign angle = angle_ff;

endmodule
`default_nettype wire

/* src/qte_back.sv */
`default_nettype none
module qte_back #(
   parameter int CORDIC_STEPS = qte_pkg::CordicStepsDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  qte_pkg::qte_item_type                   in_item,
   input  wire logic                               in_valid,
   output logic                                    out_strobe,
   output logic signed [qte_pkg::RollW-1:0]        out_roll,
   output logic signed [qte_pkg::PitchW-1:0]       out_pitch,
   output logic signed [qte_pkg::YawW-1:0]         out_yaw,
   output logic                                    out_clamped
);
   import qte_pkg::*;

   localparam int RootLat = 2 + IsqrtStages;
   localparam int AtanLat = AtanFixedStages + CORDIC_STEPS;

   function automatic logic signed [AngOutW-1:0] sat_ang(
      input logic signed [AngOutW-1:0] a,
      input logic signed [AngOutW-1:0] lim
   );
      logic signed [AngOutW-1:0] r;
      if (a > lim) begin
         r = lim;
      end else if (a < -lim) begin
         r = -lim;
      end else begin
         r = a;
      end
      return r;
   endfunction

   qte_item_type            item_b0_ff;
   logic                    v_b0_ff;
   logic [2*MagW-1:0]       sq_ff;
   logic [RadW-1:0]         rad_ff;
   logic [RootW-1:0]        root;

   qte_item_type            ditem_ff [RootLat];
   logic                    dv_ff [RootLat];
   qte_item_type            ritem;

   logic                    fv_ff [AtanLat];
   logic                    fclamp_ff [AtanLat];
   logic                    fneg_ff [AtanLat];

   logic signed [SumW-1:0]  pitch_y, pitch_x;
   logic signed [AngOutW-1:0] roll_ang, pitch_ang, yaw_ang;
   logic signed [AngOutW-1:0] roll_sat, pitch_sat, yaw_sat;

   logic                    strobe_ff;
   logic signed [RollW-1:0] roll_ff;
   logic signed [PitchW-1:0] pitch_ff;
   logic signed [YawW-1:0]  yaw_ff;
   logic                    clamped_ff;

   always_ff @(posedge clock) begin
      item_b0_ff <= in_item;
      sq_ff      <= item_b0_ff.pitch_mag * item_b0_ff.pitch_mag;
      rad_ff     <= (RadW'(1) << (2 * MagW)) - RadW'(sq_ff);
   end

   qte_isqrt u_isqrt (
      .clock    (clock),
      .radicand (rad_ff),
      .root     (root)
   );

   // The sine and cosine terms wait here while the pitch cosine is formed.
   always_ff @(posedge clock) begin
      ditem_ff[0] <= item_b0_ff;
      for (int i = 1; i < RootLat; i++) begin
         ditem_ff[i] <= ditem_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_b0_ff <= 1'b0;
         for (int i = 0; i < RootLat; i++) begin
            dv_ff[i] <= 1'b0;
         end
         for (int i = 0; i < AtanLat; i++) begin
            fv_ff[i] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         v_b0_ff  <= in_valid;
         dv_ff[0] <= v_b0_ff;
         for (int i = 1; i < RootLat; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
         fv_ff[0] <= dv_ff[RootLat-1];
         for (int i = 1; i < AtanLat; i++) begin
            fv_ff[i] <= fv_ff[i-1];
         end
         strobe_ff <= fv_ff[AtanLat-1];
      end
   end

   assign ritem   = ditem_ff[RootLat-1];
   assign pitch_y = ritem.pitch_neg ? -SumW'(ritem.pitch_mag) : SumW'(ritem.pitch_mag);
   assign pitch_x = SumW'(root);

   qte_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock),
      .y_in  (ritem.sin_roll),
      .x_in  (ritem.cos_roll),
      .angle (roll_ang)
   );

   qte_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock),
      .y_in  (pitch_y),
      .x_in  (pitch_x),
      .angle (pitch_ang)
   );

   qte_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock),
      .y_in  (ritem.sin_yaw),
      .x_in  (ritem.cos_yaw),
      .angle (yaw_ang)
   );

   always_ff @(posedge clock) begin
      fclamp_ff[0] <= ritem.pitch_clamped;
      fneg_ff[0]   <= ritem.pitch_neg;
      for (int i = 1; i < AtanLat; i++) begin
         fclamp_ff[i] <= fclamp_ff[i-1];
         fneg_ff[i]   <= fneg_ff[i-1];
      end
   end

   always_comb begin
      roll_sat = sat_ang(roll_ang, Lim180);
      yaw_sat  = sat_ang(yaw_ang, Lim180);
      if (fclamp_ff[AtanLat-1]) begin
         pitch_sat = fneg_ff[AtanLat-1] ? -Lim90 : Lim90;
      end else begin
         pitch_sat = sat_ang(pitch_ang, Lim90);
      end
   end

   always_ff @(posedge clock) begin
      roll_ff    <= RollW'(roll_sat);
      pitch_ff   <= PitchW'(pitch_sat);
      yaw_ff     <= YawW'(yaw_sat);
      clamped_ff <= fclamp_ff[AtanLat-1];
   end

   assign out_strobe  = strobe_ff;
   assign out_roll    = roll_ff;
   assign out_pitch   = pitch_ff;
   assign out_yaw     = yaw_ff;
   assign out_clamped = clamped_ff;

endmodule
`default_nettype wire

/* src/quaternion_to_euler_angles.sv */
// Throughput: one quaternion per cycle while busy is low; the three CORDIC pipelines
// and the pipelined square root for the pitch cosine each take a new operand every cycle.
// busy rises only if the queue between front and back fills; the receiver cannot stall.
// Reset (synchronous, active high) empties the queue and drops every item in flight.
`default_nettype none
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = qte_pkg::CordicStepsDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [qte_pkg::QuatW-1:0]  req_quat_w,
   input  wire logic signed [qte_pkg::QuatW-1:0]  req_quat_x,
   input  wire logic signed [qte_pkg::QuatW-1:0]  req_quat_y,
   input  wire logic signed [qte_pkg::QuatW-1:0]  req_quat_z,
   output logic                                   rsp_strobe,
   output logic signed [qte_pkg::RollW-1:0]       rsp_roll_angle,
   output logic signed [qte_pkg::PitchW-1:0]      rsp_pitch_angle,
   output logic signed [qte_pkg::YawW-1:0]        rsp_yaw_angle,
   output logic                                   rsp_pitch_clamped
);
   import qte_pkg::*;

   logic         accept;
   qte_item_type front_item, queue_item;
   logic         front_valid, queue_valid, almost_full;

   assign accept = start && !busy;
   assign busy   = almost_full;

   qte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .quat_w     (req_quat_w),
      .quat_x     (req_quat_x),
      .quat_y     (req_quat_y),
      .quat_z     (req_quat_z),
      .item       (front_item),
      .item_valid (front_valid)
   );

   qte_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (front_valid),
      .push_item   (front_item),
      .pop_item    (queue_item),
      .pop_valid   (queue_valid),
      .almost_full (almost_full)
   );

   qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_item     (queue_item),
      .in_valid    (queue_valid),
      .out_strobe  (rsp_strobe),
      .out_roll    (rsp_roll_angle),
      .out_pitch   (rsp_pitch_angle),
      .out_yaw     (rsp_yaw_angle),
      .out_clamped (rsp_pitch_clamped)
   );

`ifndef ASSERT_OFF
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_pitch_clamped |->
         rsp_pitch_angle == PitchW'(Lim90) || rsp_pitch_angle == -PitchW'(Lim90))
      else $error("clamped pitch is not at a pole");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_pitch_angle <= PitchW'(Lim90) && rsp_pitch_angle >= -PitchW'(Lim90))
      else $error("pitch outside ninety degrees");

   a_roll_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_roll_angle <= RollW'(Lim180) && rsp_roll_angle >= -RollW'(Lim180)
         && rsp_yaw_angle <= YawW'(Lim180) && rsp_yaw_angle >= -YawW'(Lim180))
      else $error("roll or yaw outside half circle");
`endif

endmodule
`default_nettype wire

/* tb/tb_quaternion_to_euler_angles.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_quaternion_to_euler_angles;
   import qte_pkg::*;

   localparam int StepCount = CordicStepsDefault;
   localparam int FracBits = QuatFracBits;
   localparam int RandomItems = 550;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles = 120;

   typedef struct {
      logic signed [QuatW-1:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [RollW-1:0]  roll;
      logic signed [PitchW-1:0] pitch;
      logic signed [YawW-1:0]   yaw;
      logic                     clamped;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [QuatW-1:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_strobe;
   logic signed [RollW-1:0]  rsp_roll_angle;
   logic signed [PitchW-1:0] rsp_pitch_angle;
   logic signed [YawW-1:0]   rsp_yaw_angle;
   logic rsp_pitch_clamped;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;
   bit  took_item = 1'b0;
   int  gap_left = 0;

   quaternion_to_euler_angles dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_strobe(rsp_strobe), .rsp_roll_angle(rsp_roll_angle),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_pitch_clamped(rsp_pitch_clamped)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint shift_right_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint ax, ay, m, xs, ys, acc, dx, dy;
      ax = abs64(x);
      ay = abs64(y);
      m = ax > ay ? ax : ay;
      acc = 0;
      if (m == 0) return 0;
      while (m >= (64'sd1 <<< 30)) begin
         m = m >> 1; ax = ax >> 1; ay = ay >> 1;
      end
      while (m < (64'sd1 <<< 29)) begin
         m = m << 1; ax = ax << 1; ay = ay << 1;
      end
      xs = ax;
      if (x < 0) begin
         acc = y < 0 ? -longint'(Deg180Fine) : longint'(Deg180Fine);
         ys = y < 0 ? ay : -ay;
      end else begin
         ys = y < 0 ? -ay : ay;
      end
      for (int i = 0; i < StepCount && i < TableLen; i++) begin
         dx = shift_right_floor(ys, i);
         dy = shift_right_floor(xs, i);
         if (ys >= 0) begin
            xs += dx; ys -= dy; acc += longint'(atan_fine(i));
         end else begin
            xs -= dx; ys += dy; acc -= longint'(atan_fine(i));
         end
      end
      return acc;
   endfunction

   function automatic longint fine_to_units(longint fine, longint lim);
      longint r;
      r = shift_right_floor(fine + 32768, FineShift);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic euler_type quat_to_euler(quat_type q);
      euler_type e;
      longint w, x, y, z, unity, sr, cr, sp, sy, cy, ms, s30, p;
      longint unsigned c;
      w = q.w; x = q.x; y = q.y; z = q.z;
      unity = 64'sd1 <<< (2 * FracBits);
      sr = 2 * (w * x + y * z);
      cr = unity - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = unity - 2 * (y * y + z * z);
      e.roll = RollW'(fine_to_units(vector_angle(sr, cr), 11520));
      e.yaw = YawW'(fine_to_units(vector_angle(sy, cy), 11520));
      if (abs64(sp) >= unity) begin
         p = sp < 0 ? -5760 : 5760;
         e.clamped = 1'b1;
      end else begin
         ms = abs64(sp);
         if (2 * FracBits >= 30) ms = ms >> (2 * FracBits - 30);
         else ms = ms << (30 - 2 * FracBits);
         c = root_floor((64'd1 << 60) - longint'(ms) * longint'(ms));
         s30 = sp < 0 ? -ms : ms;
         p = fine_to_units(vector_angle(s30, longint'(c)), 5760);
         e.clamped = 1'b0;
      end
      e.pitch = PitchW'(p);
      return e;
   endfunction

   function automatic quat_type make_quat(int w, int x, int y, int z);
      quat_type q;
      q.w = QuatW'(w); q.x = QuatW'(x); q.y = QuatW'(y); q.z = QuatW'(z);
      return q;
   endfunction

   function automatic int rand_component();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return int'($urandom_range(0, 65535)) - 32768;
      if (sel == 1) return $urandom_range(0, 1) ? 16384 : -16384;
      return int'($urandom_range(0, 32768)) - 16384;
   endfunction

   // Roughly unit quaternions reach the interesting part of the angle range.
   function automatic quat_type rand_unit_quat();
      real a, b, c, d, n;
      a = real'(rand_component()); b = real'(rand_component());
      c = real'(rand_component()); d = real'(rand_component());
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) return make_quat(16384, 0, 0, 0);
      return make_quat(int'(a * 16384.0 / n), int'(b * 16384.0 / n),
                       int'(c * 16384.0 / n), int'(d * 16384.0 / n));
   endfunction

   initial begin
      pending_quats.push_back(make_quat(16384, 0, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 0, 0));
      pending_quats.push_back(make_quat(-16384, 0, 0, 0));
      pending_quats.push_back(make_quat(0, 16384, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 16384, 0));
      pending_quats.push_back(make_quat(0, 0, 0, 16384));
      // Near gimbal lock: the pitch sine falls just short of plus and minus one, or just passes plus one.
      pending_quats.push_back(make_quat(11585, 0, 11585, 0));
      pending_quats.push_back(make_quat(11585, 0, -11585, 0));
      pending_quats.push_back(make_quat(11586, 0, 11586, 0));
      pending_quats.push_back(make_quat(11584, 0, 11584, 0));
      pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
      pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
      pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
      pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
      pending_quats.push_back(make_quat(0, 11585, 0, 11585));
      pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
      pending_quats.push_back(make_quat(1, -1, 1, -1));
      pending_quats.push_back(make_quat(11585, 11585, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 0, -16384));
      for (int i = 0; i < RandomItems; i++) begin
         if ($urandom_range(0, 3) == 0)
            pending_quats.push_back(make_quat(rand_component(), rand_component(),
                                              rand_component(), rand_component()));
         else
            pending_quats.push_back(rand_unit_quat());
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Driver: after each transfer the falling edge presents a new item or starts a random gap.
   // Whether the last rising edge took the item is recorded by the monitor,
   // since busy may already have changed by the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (took_item) begin
            expected_angles.push_back(quat_to_euler(make_quat(req_quat_w, req_quat_x,
                                                              req_quat_y, req_quat_z)));
            gap_left = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
         end
         if (start && !took_item) begin
            // hold the current item
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_quats.size() > 0) begin
            quat_type q;
            q = pending_quats.pop_front();
            req_quat_w <= q.w; req_quat_x <= q.x;
            req_quat_y <= q.y; req_quat_z <= q.z;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            stimulus_done = 1'b1;
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         took_item <= start && !busy;
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            if (expected_angles.size() == 0) begin
               $error("unexpected result transfer");
               error_count++;
            end else begin
               euler_type e;
               e = expected_angles.pop_front();
               if (rsp_roll_angle !== e.roll) begin
                  $error("roll_angle expected %0d actual %0d", e.roll, rsp_roll_angle);
                  error_count++;
               end
               if (rsp_pitch_angle !== e.pitch) begin
                  $error("pitch_angle expected %0d actual %0d", e.pitch, rsp_pitch_angle);
                  error_count++;
               end
               if (rsp_yaw_angle !== e.yaw) begin
                  $error("yaw_angle expected %0d actual %0d", e.yaw, rsp_yaw_angle);
                  error_count++;
               end
               if (rsp_pitch_clamped !== e.clamped) begin
                  $error("pitch_clamped expected %0d actual %0d", e.clamped,
                         rsp_pitch_clamped);
                  error_count++;
               end
            end
         end
      end else begin
         took_item <= 1'b0;
      end
   end

   initial begin
      wait (!reset);
      while (!(stimulus_done && expected_angles.size() == 0)
             && idle_cycles < WatchdogLimit)
         @(posedge clock);
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: failure");
      end else begin
         repeat (DrainCycles) @(posedge clock);
         if (error_count == 0) $display("tb: success");
         else $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
